// File: hdl/parallel_camera_frame_capture_unit_defines.svh
// Assertion macros used by the camera capture core.
`ifndef PARALLEL_CAMERA_FRAME_CAPTURE_UNIT_DEFINES_SVH
`define PARALLEL_CAMERA_FRAME_CAPTURE_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PCFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PCFC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hdl/pcfc_pkg.sv
// Shared types and constants of the parallel camera capture unit.
package pcfc_pkg;

    // Counter widths
    localparam int LINE_COUNT_BITS = 10;
    localparam int BYTE_COUNT_BITS = 12;

    // Field and register widths
    localparam int LINES_W    = 10;
    localparam int BYTES_W    = 12;
    localparam int COLUMN_W   = 12;
    localparam int LINE_W     = 10;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    // Register reset values
    localparam logic [LINES_W-1:0] LINES_RESET = LINES_W'(480);
    localparam logic [BYTES_W-1:0] BYTES_RESET = BYTES_W'(1280);

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_LINES_PER_FRAME = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BYTES_PER_LINE  = 2'd1;

    // Result kinds
    localparam logic [1:0] KIND_PIXEL     = 2'd0;
    localparam logic [1:0] KIND_DONE      = 2'd1;
    localparam logic [1:0] KIND_VSYNC_ERR = 2'd2;
    localparam logic [1:0] KIND_HREF_ERR  = 2'd3;

    typedef logic [LINE_COUNT_BITS-1:0] t_lcnt;
    typedef logic [BYTE_COUNT_BITS-1:0] t_bcnt;

    typedef struct packed {
        logic       cmd;
        logic       vsync;
        logic       href;
        logic       pclk;
        logic [7:0] bus_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          kind;
        logic [7:0]          pixel;
        logic [COLUMN_W-1:0] column;
        logic [LINE_W-1:0]   line;
        logic                last_in_line;
        logic                last_in_frame;
    } t_out_item;

    // One capture step result
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_step_res;

    // Capture sequencer phases
    typedef enum logic [6:0] {
        PH_IDLE      = 7'b0000001,
        PH_VS_HIGH   = 7'b0000010,
        PH_VS_LOW    = 7'b0000100,
        PH_HREF_HIGH = 7'b0001000,
        PH_PCLK_HIGH = 7'b0010000,
        PH_PCLK_LOW  = 7'b0100000,
        PH_HREF_LOW  = 7'b1000000
    } t_phase;

endpackage

// File: hdl/parallel_camera_frame_capture_unit.sv
// Top level of the parallel camera frame capture unit.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item): one oversampled pin
//   sample of the camera bus per transfer, or a start command (cmd = 1) that
//   arms a new frame capture and restarts one already running.
//   Output channel (o_out_valid / i_out_stall / o_out_item): pixel bytes with
//   column, line and last flags, frame done, and the two error reports.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   index 0 writes lines per frame, index 1 bytes per line. Write only idle.
// Timing:
//   One sample per cycle is taken while the output does not stall. A result
//   reaches the output through the input register, then the result register.
//   The limit is the one-step sequencer between those two registers.
// Reset:
//   Sequencer goes idle, registers return to 480 lines and 1280 bytes.
// Stall:
//   A stalled result holds; the next sample still enters the input register,
//   and further samples stall only while that register cannot move on.
module parallel_camera_frame_capture_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  pcfc_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output pcfc_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pcfc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [pcfc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import pcfc_pkg::*;

    logic [LINES_W-1:0] r_lines_per_frame;
    logic [BYTES_W-1:0] r_bytes_per_line;

    logic      in_full;
    t_in_item  in_item;
    logic      out_room;
    logic      adv;
    t_step_res step_res;

    // Configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lines_per_frame <= LINES_RESET;
            r_bytes_per_line  <= BYTES_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LINES_PER_FRAME: r_lines_per_frame <= LINES_W'(i_cfg_data);
                CFG_BYTES_PER_LINE:  r_bytes_per_line  <= BYTES_W'(i_cfg_data);
                default: begin
                    r_lines_per_frame <= r_lines_per_frame;
                end
            endcase
        end
    end

    // Move the held sample on when the result register has room
    assign adv = in_full && out_room;

    pcfc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_stall (o_in_stall),
        .i_adv   (adv),
        .o_full  (in_full),
        .o_item  (in_item)
    );

    pcfc_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (adv),
        .i_item            (in_item),
        .i_lines_per_frame (r_lines_per_frame),
        .i_bytes_per_line  (r_bytes_per_line),
        .o_res             (step_res)
    );

    pcfc_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step_res.valid),
        .i_item      (step_res.item),
        .i_out_stall (i_out_stall),
        .o_room      (out_room),
        .o_valid     (o_out_valid),
        .o_item      (o_out_item)
    );

endmodule

// File: hdl/pcfc_in_stage.sv
// Input register of the capture unit: holds one pin sample until the core takes it.
module pcfc_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  pcfc_pkg::t_in_item i_item,
    output logic              o_stall,
    input  logic              i_adv,
    output logic              o_full,
    output pcfc_pkg::t_in_item o_item
);
    import pcfc_pkg::*;

    logic     r_full;
    logic     n_full;
    t_in_item r_item;
    logic     accept;

    // Stall only while a held sample cannot move on
    assign o_stall = r_full && !i_adv;
    assign accept  = i_valid && !o_stall;
    assign n_full  = accept || (r_full && !i_adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else begin
            r_full <= n_full;
        end
    end

    // Capture the sample on each transfer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_full = r_full;
    assign o_item = r_item;

endmodule

// File: hdl/pcfc_core.sv
// Capture sequencer: frame/line/byte tracking and result formation.
module pcfc_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  pcfc_pkg::t_in_item             i_item,
    input  logic [pcfc_pkg::LINES_W-1:0]   i_lines_per_frame,
    input  logic [pcfc_pkg::BYTES_W-1:0]   i_bytes_per_line,
    output pcfc_pkg::t_step_res            o_res
);
    import pcfc_pkg::*;

    `include "parallel_camera_frame_capture_unit_defines.svh"

    t_phase     r_phase;
    t_phase     n_phase;
    logic [7:0] r_held_byte;
    logic [7:0] n_held_byte;
    t_lcnt      r_line_count;
    t_lcnt      n_line_count;
    t_bcnt      r_byte_count;
    t_bcnt      n_byte_count;

    t_lcnt      line_inc;
    t_bcnt      byte_inc;
    t_lcnt      lines_cfg;
    t_bcnt      bytes_cfg;
    logic       line_last;
    logic       frame_last;
    t_step_res  res;

    // Compare next counts against the configured sizes
    assign lines_cfg  = LINE_COUNT_BITS'(i_lines_per_frame);
    assign bytes_cfg  = BYTE_COUNT_BITS'(i_bytes_per_line);
    assign line_inc   = r_line_count + LINE_COUNT_BITS'(1);
    assign byte_inc   = r_byte_count + BYTE_COUNT_BITS'(1);
    assign line_last  = (byte_inc == bytes_cfg);
    assign frame_last = (line_inc == lines_cfg);

    // Advance the sequencer by one pin sample
    always_comb begin
        n_phase      = r_phase;
        n_held_byte  = r_held_byte;
        n_line_count = r_line_count;
        n_byte_count = r_byte_count;
        res          = '0;
        if (i_step) begin
            if (i_item.cmd) begin
                n_phase      = PH_VS_HIGH;
                n_line_count = '0;
                n_byte_count = '0;
            end else begin
                case (r_phase)
                    PH_IDLE: begin
                        n_phase = PH_IDLE;
                    end
                    PH_VS_HIGH: begin
                        if (i_item.vsync) begin
                            n_phase = PH_VS_LOW;
                        end
                    end
                    PH_VS_LOW: begin
                        if (!i_item.vsync) begin
                            n_phase = PH_HREF_HIGH;
                        end
                    end
                    PH_HREF_HIGH: begin
                        // VSYNC during the line wait wins over HREF
                        if (i_item.vsync) begin
                            res.valid     = 1'b1;
                            res.item.kind = KIND_VSYNC_ERR;
                            res.item.line = LINE_W'(r_line_count);
                            n_phase       = PH_IDLE;
                        end else if (i_item.href) begin
                            n_byte_count = '0;
                            n_phase      = PH_PCLK_HIGH;
                        end
                    end
                    PH_PCLK_HIGH: begin
                        if (i_item.pclk) begin
                            n_held_byte = i_item.bus_data;
                            n_phase     = PH_PCLK_LOW;
                        end
                    end
                    PH_PCLK_LOW: begin
                        // HREF dropping before the line is full is checked first
                        if (!i_item.href && !line_last) begin
                            res.valid       = 1'b1;
                            res.item.kind   = KIND_HREF_ERR;
                            res.item.column = COLUMN_W'(r_byte_count);
                            res.item.line   = LINE_W'(r_line_count);
                            n_phase         = PH_IDLE;
                        end else if (!i_item.pclk) begin
                            res.valid              = 1'b1;
                            res.item.kind          = KIND_PIXEL;
                            res.item.pixel         = r_held_byte;
                            res.item.column        = COLUMN_W'(r_byte_count);
                            res.item.line          = LINE_W'(r_line_count);
                            res.item.last_in_line  = line_last;
                            res.item.last_in_frame = line_last && frame_last;
                            n_byte_count           = byte_inc;
                            n_phase = line_last ? PH_HREF_LOW : PH_PCLK_HIGH;
                        end
                    end
                    PH_HREF_LOW: begin
                        if (!i_item.href) begin
                            n_line_count = line_inc;
                            if (frame_last) begin
                                res.valid     = 1'b1;
                                res.item.kind = KIND_DONE;
                                n_phase       = PH_IDLE;
                            end else begin
                                n_phase = PH_HREF_HIGH;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_line_count <= '0;
            r_byte_count <= '0;
        end else begin
            r_phase      <= n_phase;
            r_line_count <= n_line_count;
            r_byte_count <= n_byte_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held_byte <= n_held_byte;
    end

    assign o_res = res;

    `PCFC_ASSERT(a_res_phase, o_res.valid |-> (r_phase == PH_HREF_HIGH || r_phase == PH_PCLK_LOW || r_phase == PH_HREF_LOW), "result from a phase that cannot emit")
    `PCFC_ASSERT(a_end_idle, (o_res.valid && o_res.item.kind != KIND_PIXEL) |=> (r_phase == PH_IDLE), "error or done did not return to idle")
    `PCFC_ASSERT(a_line_end, (o_res.valid && o_res.item.kind == KIND_PIXEL && o_res.item.last_in_line) |=> (r_phase == PH_HREF_LOW), "last byte of line not followed by HREF low wait")
    `PCFC_ASSERT(a_no_step_hold, !i_step |=> $stable(r_phase), "phase moved without a sample")

endmodule

// File: hdl/pcfc_out_stage.sv
// Result register of the capture unit: holds one result until the receiver takes it.
module pcfc_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  pcfc_pkg::t_out_item i_item,
    input  logic                i_out_stall,
    output logic                o_room,
    output logic                o_valid,
    output pcfc_pkg::t_out_item o_item
);
    import pcfc_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_out_item r_item;

    // Free when empty or when the held result transfers now
    assign o_room  = !r_valid || !i_out_stall;
    assign n_valid = i_load || (r_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
